/* hdl/kbs_pkg.sv */
// Package for the keyframe bracket search unit: opcodes, register indexes,
// widths and the request record passed from the front to the back end.
`timescale 1ns / 1ps
package kbs_pkg;
    localparam int unsigned MaxFrames = 1024;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CountW = 11;
    localparam int unsigned TolW   = 16;
    localparam int unsigned FrameW = 16;
    localparam int unsigned IdxOutW = 10;
    localparam int unsigned AlphaW = 17;

    typedef enum logic {
        t_op_load  = 1'b0,
        t_op_query = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_FRAME_DELTA = 2'd0,
        REG_FRAME_COUNT = 2'd1,
        REG_NEAR_TOL    = 2'd2
    } t_reg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_FAST,
        S_MUL,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_LO,
        S_RD_HI,
        S_FRAC,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [FrameW-1:0] frame_number;
    } t_query;
endpackage

/* hdl/kbs_front.sv */
// Front end of the keyframe bracket search: accepts requests, writes loads
// into the key table write port and queues queries. Depends on kbs_pkg.
`timescale 1ns / 1ps
module kbs_front
    import kbs_pkg::*;
#(
    parameter int unsigned AddrW = 10,
    parameter int unsigned Depth = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [9:0]        i_entry_index,
    input  logic [TimeW-1:0]  i_frame_time,
    input  logic [FrameW-1:0] i_frame_number,
    input  logic              i_back_idle,
    output logic              o_wr_en,
    output logic [AddrW-1:0]  o_wr_addr,
    output logic [TimeW-1:0]  o_wr_data,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output t_query            o_q
);
    localparam int unsigned PtrW = $clog2(Depth);
    t_query            r_mem [Depth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;
    logic              w_acc, w_push, w_pop, w_in_range;

    // A load waits until every earlier query has finished with the table.
    assign o_ready = (r_cnt != (PtrW+1)'(Depth)) &&
                     ((i_opcode == t_op_query) || ((r_cnt == '0) && i_back_idle));
    assign w_acc   = i_valid && o_ready;
    assign w_push  = w_acc && (i_opcode == t_op_query);
    assign w_pop   = o_q_valid && i_q_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q     = r_mem[r_rp];

    if (AddrW >= 10) begin : g_rng
        assign w_in_range = 1'b1;
    end else begin : g_rng
        assign w_in_range = (i_entry_index < 10'(1 << AddrW));
    end
    assign o_wr_en   = w_acc && (i_opcode == t_op_load) && w_in_range;
    assign o_wr_addr = AddrW'(i_entry_index);
    assign o_wr_data = i_frame_time;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{frame_number: i_frame_number};
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PtrW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PtrW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end
endmodule

/* hdl/kbs_back.sv */
// Back end of the keyframe bracket search: key table memory, fast path,
// bisection search and serial divider for alpha. Depends on kbs_pkg.
`timescale 1ns / 1ps
module kbs_back
    import kbs_pkg::*;
#(
    parameter int unsigned AddrW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AddrW-1:0]   i_wr_addr,
    input  logic [TimeW-1:0]   i_wr_data,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  t_query             i_q,
    input  logic [TimeW-1:0]   i_frame_delta,
    input  logic [CountW-1:0]  i_frame_count,
    input  logic [TolW-1:0]    i_near_tol,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IdxOutW-1:0] o_first_index,
    output logic [IdxOutW-1:0] o_second_index,
    output logic [AlphaW-1:0]  o_alpha,
    output logic               o_status
);
    localparam int unsigned NW = AddrW + 1;
    localparam int unsigned MaxN = 1 << AddrW;

    logic [TimeW-1:0] r_mem [MaxN];
    logic [TimeW-1:0] r_rd;
    logic [AddrW-1:0] w_rd_addr;

    t_state r_state, n_state;
    logic [NW-1:0]    r_n;
    logic [AddrW-1:0] r_b, r_e, r_lo, r_hi;
    logic [FrameW-1:0] r_fn;
    logic [TimeW-1:0] r_t0, r_tlo, r_w;
    logic [TimeW+FrameW-1:0] r_prod;
    logic             r_fastok;
    logic [TimeW:0]   r_rem, r_den;
    logic [16:0]      r_quo;
    logic [4:0]       r_cnt;
    logic [IdxOutW-1:0] r_o_first, r_o_second;
    logic [AlphaW-1:0]  r_o_alpha;
    logic               r_o_status;

    logic [NW-1:0]    w_n;
    logic [AddrW-1:0] w_m;
    logic [TimeW:0]   w_d, w_num, w_dena, w_sub, w_mn, w_md;
    logic             w_near_m, w_near_d, w_div_go, w_geq;
    logic [TimeW+FrameW:0] w_wsum;

    assign w_n  = (i_frame_count > CountW'(MaxN)) ? NW'(MaxN) : NW'(i_frame_count);
    assign w_m  = AddrW'(({1'b0, r_b} + {1'b0, r_e}) >> 1);

    // Absolute difference of T[1]-T[0] against frame_delta.
    assign w_d = (r_rd >= r_t0) ? {1'b0, r_rd - r_t0} : {1'b0, r_t0 - r_rd};
    always_comb begin
        w_near_d = 1'b0;
        if (r_rd >= r_t0) begin
            w_near_d = ((w_d >= {1'b0, i_frame_delta}) ?
                        (w_d - {1'b0, i_frame_delta}) :
                        ({1'b0, i_frame_delta} - w_d)) <= (TimeW+1)'(i_near_tol);
        end else begin
            w_near_d = (w_d + {1'b0, i_frame_delta}) <= (TimeW+1)'(i_near_tol);
        end
    end
    assign w_near_m = ((r_rd >= r_w) ? (r_rd - r_w) : (r_w - r_rd)) <= TimeW'(i_near_tol);
    assign w_wsum = {1'b0, r_prod} + (TimeW+FrameW+1)'(r_t0);
    assign w_num  = {1'b0, r_w} - {1'b0, r_tlo};
    assign w_dena = {1'b0, r_rd} - {1'b0, r_tlo};
    assign w_mn   = w_num[TimeW] ? (~w_num + 1'b1) : w_num;
    assign w_md   = w_dena[TimeW] ? (~w_dena + 1'b1) : w_dena;
    assign w_div_go = (r_rd != r_tlo) && (r_w != r_tlo) &&
                      (w_num[TimeW] == w_dena[TimeW]) && (w_mn <= w_md);
    assign w_sub  = r_rem - r_den;
    assign w_geq  = (r_rem >= r_den);

    always_comb begin
        unique case (r_state)
            S_RD0:      w_rd_addr = '0;
            S_RD1:      w_rd_addr = AddrW'(1);
            S_SRCH_RD:  w_rd_addr = w_m;
            S_RD_LO:    w_rd_addr = r_lo;
            S_RD_HI:    w_rd_addr = r_hi;
            default:    w_rd_addr = r_hi;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rd <= r_mem[w_rd_addr];
    end

    assign o_q_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_q_valid) n_state = (w_n < NW'(2)) ? S_OUT : S_RD0;
            S_RD0:      n_state = S_RD1;
            S_RD1:      n_state = S_FAST;
            S_FAST:     n_state = S_MUL;
            S_MUL:      n_state = (r_fastok && ({5'd0, r_fn} < r_n)) ? S_OUT : S_SRCH_RD;
            S_SRCH_RD:  n_state = ((w_m == r_b) || (w_m == r_e)) ? S_RD_LO : S_SRCH_CMP;
            S_SRCH_CMP: n_state = w_near_m ? S_OUT : S_SRCH_RD;
            S_RD_LO:    n_state = S_RD_HI;
            S_RD_HI:    n_state = S_FRAC;
            S_FRAC:     n_state = w_div_go ? S_DIV : S_OUT;
            S_DIV:      n_state = (r_cnt == 5'd0) ? S_OUT : S_DIV;
            S_OUT:      if (o_valid && i_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n  <= w_n;
                r_fn <= i_q.frame_number;
                r_o_first  <= '0;
                r_o_second <= '0;
                r_o_alpha  <= '0;
                r_o_status <= (w_n == '0);
            end
            S_RD1: begin
                r_t0 <= r_rd;
            end
            S_FAST: begin
                r_fastok <= (r_t0 <= TimeW'(i_near_tol)) && w_near_d;
                r_prod <= i_frame_delta * r_fn;
                r_b <= '0;
                r_e <= AddrW'(r_n - 1'b1);
                r_o_first  <= IdxOutW'(r_fn);
                r_o_second <= IdxOutW'(r_fn);
            end
            S_MUL: begin
                r_w <= (w_wsum > (TimeW+FrameW+1)'(32'hFFFF_FFFF)) ? '1 : TimeW'(w_wsum);
            end
            S_SRCH_RD: begin
                r_lo <= r_b;
                r_hi <= r_e;
                r_o_first  <= IdxOutW'(w_m);
                r_o_second <= IdxOutW'(w_m);
            end
            S_SRCH_CMP: begin
                if (!w_near_m) begin
                    if (r_rd < r_w) r_b <= w_m;
                    else r_e <= w_m;
                end
            end
            S_RD_HI: begin
                r_tlo <= r_rd;
            end
            S_FRAC: begin
                r_o_first  <= IdxOutW'(r_lo);
                r_o_second <= IdxOutW'(r_hi);
                r_rem <= w_mn;
                r_den <= w_md;
                r_cnt <= 5'd16;
                r_quo <= '0;
                if (r_rd != r_tlo && r_w != r_tlo) begin
                    if (w_num[TimeW] != w_dena[TimeW]) begin
                        r_o_first <= '0;
                        r_o_second <= '0;
                    end else if (w_mn > w_md) begin
                        r_o_first  <= IdxOutW'(r_n - 1'b1);
                        r_o_second <= IdxOutW'(r_n - 1'b1);
                    end
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit a cycle; the remainder
                // stays below twice the divisor.
                if (w_geq) begin
                    r_rem <= {w_sub[TimeW-1:0], 1'b0};
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[TimeW-1:0], 1'b0};
                    r_quo <= {r_quo[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd0) r_o_alpha <= {r_quo[15:0], w_geq};
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_first_index  = r_o_first;
    assign o_second_index = r_o_second;
    assign o_alpha        = r_o_alpha;
    assign o_status       = r_o_status;
endmodule

/* hdl/keyframe_bracket_search_unit.sv */
// Top level of the keyframe bracket search unit: configuration registers,
// front end and back end. Depends on kbs_pkg, kbs_front and kbs_back.
`timescale 1ns / 1ps
// Use: load requests (opcode 0) write one key time into the table and give
// no result; query requests (opcode 1) give one result with two bracketing
// indices, an alpha fraction and a status. Both channels use valid/ready.
// A load waits until every earlier query has finished. A taken query is
// registered in the queue before it reaches the back end. Tables with
// fewer than two keys go straight to the result; otherwise the first two
// keys are read for the fast path; failing that, a bisection search (at
// most 10 steps), reads of the bracketing keys and, if alpha is needed, the
// serial divider (one bit a cycle) follow. The table has one read port.
// Up to four queries wait in the queue.
// Reset clears the queue, the control state and the configuration registers
// to their reset values; the table holds nothing defined until it is written.
// When the receiver stalls, the result is held and the back end stops;
// the front end keeps taking queries until the queue is full.
// The user must write configuration only while the block is idle; unchecked.
module keyframe_bracket_search_unit
    import kbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_opcode,
    input  logic [9:0]         i_entry_index,
    input  logic [TimeW-1:0]   i_frame_time,
    input  logic [FrameW-1:0]  i_frame_number,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IdxOutW-1:0] o_first_index,
    output logic [IdxOutW-1:0] o_second_index,
    output logic [AlphaW-1:0]  o_alpha,
    output logic               o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [TimeW-1:0]   i_cfg_data
);
    localparam int unsigned AddrW = $clog2(MaxFrames);

    logic [TimeW-1:0]  r_frame_delta;
    logic [CountW-1:0] r_frame_count;
    logic [TolW-1:0]   r_near_tol;
    logic              w_wr_en, w_q_valid, w_q_ready;
    logic [AddrW-1:0]  w_wr_addr;
    logic [TimeW-1:0]  w_wr_data;
    t_query            w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_delta <= TimeW'(2185);
            r_frame_count <= '0;
            r_near_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_DELTA: r_frame_delta <= i_cfg_data;
                REG_FRAME_COUNT: r_frame_count <= i_cfg_data[CountW-1:0];
                REG_NEAR_TOL:    r_near_tol    <= i_cfg_data[TolW-1:0];
                default: begin
                end
            endcase
        end
    end

    kbs_front #(.AddrW(AddrW), .Depth(4)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_entry_index,
        .i_frame_time, .i_frame_number, .i_back_idle(w_q_ready),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr), .o_wr_data(w_wr_data),
        .o_q_valid(w_q_valid), .i_q_ready(w_q_ready), .o_q(w_q)
    );

    kbs_back #(.AddrW(AddrW)) u_back (
        .i_clk, .i_rst_n,
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_data(w_wr_data),
        .i_q_valid(w_q_valid), .o_q_ready(w_q_ready), .i_q(w_q),
        .i_frame_delta(r_frame_delta), .i_frame_count(r_frame_count),
        .i_near_tol(r_near_tol),
        .o_valid, .i_ready, .o_first_index, .o_second_index, .o_alpha, .o_status
    );
endmodule

/* tb/sv/keyframe_bracket_search_unit_tb.sv */
// Testbench for the keyframe bracket search unit: loads key tables, sets the
// registers and checks every query result against a predictor of its own.
// Depends on kbs_pkg and keyframe_bracket_search_unit.
`timescale 1ns / 1ps
module keyframe_bracket_search_unit_tb;
    import kbs_pkg::*;

    typedef struct {
        logic [IdxOutW-1:0] first;
        logic [IdxOutW-1:0] second;
        logic [AlphaW-1:0]  alpha;
        logic               status;
    } bracket_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_opcode = 1'b0;
    logic [9:0]         i_entry_index = '0;
    logic [TimeW-1:0]   i_frame_time = '0;
    logic [FrameW-1:0]  i_frame_number = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [IdxOutW-1:0] o_first_index;
    logic [IdxOutW-1:0] o_second_index;
    logic [AlphaW-1:0]  o_alpha;
    logic               o_status;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [TimeW-1:0]   i_cfg_data = '0;

    logic [31:0] stored_keys [0:1023];
    logic [31:0] delta_reg = 32'd2185;
    logic [10:0] count_reg = '0;
    logic [15:0] tol_reg = '0;
    bracket_t    pending_brackets [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          stall_left = 0;
    bit          no_idle = 1'b0;

    keyframe_bracket_search_unit i_dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic bit is_near(input longint a, input longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return d <= longint'(tol_reg);
    endfunction

    function automatic longint key_of(input longint i);
        return longint'(stored_keys[i[9:0]]);
    endfunction

    function automatic bracket_t bracket_of(input logic [15:0] fn);
        longint n, t0, w, b, e, m, lo, hi, num, den;
        bit found;
        bracket_t r;
        r = '{first: '0, second: '0, alpha: '0, status: 1'b0};
        n = (count_reg > 11'd1024) ? 1024 : longint'(count_reg);
        if (n == 0) begin
            r.status = 1'b1;
            return r;
        end
        if (n == 1) return r;
        t0 = key_of(0);
        if (t0 <= longint'(tol_reg) && is_near(key_of(1) - t0, longint'(delta_reg))
                && longint'(fn) < n) begin
            r.first = fn[9:0];
            r.second = fn[9:0];
            return r;
        end
        w = longint'(delta_reg) * longint'(fn) + t0;
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        b = 0;
        e = n - 1;
        lo = b;
        hi = e;
        found = 1'b0;
        while (!found) begin
            m = (b + e) / 2;
            if (m == b || m == e) begin
                lo = b;
                hi = e;
                found = 1'b1;
            end else if (is_near(key_of(m), w)) begin
                lo = m;
                hi = m;
                found = 1'b1;
            end else if (key_of(m) < w) begin
                b = m;
            end else begin
                e = m;
            end
        end
        r.first = lo[9:0];
        r.second = hi[9:0];
        if (lo == hi) return r;
        num = w - key_of(lo);
        den = key_of(hi) - key_of(lo);
        if (den == 0 || num == 0) return r;
        if ((num < 0) != (den < 0)) begin
            r.first = '0;
            r.second = '0;
            return r;
        end
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        if (num > den) begin
            r.first = lo[9:0] - lo[9:0] + (n[9:0] - 10'd1);
            r.second = r.first;
            return r;
        end
        r.alpha = AlphaW'((num << 16) / den);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_brackets.size() == 0) begin
                report_mismatch("result with no query waiting");
            end else begin
                bracket_t x;
                x = pending_brackets.pop_front();
                if (o_first_index !== x.first)
                    report_mismatch($sformatf("first_index %0d, wanted %0d",
                                              o_first_index, x.first));
                if (o_second_index !== x.second)
                    report_mismatch($sformatf("second_index %0d, wanted %0d",
                                              o_second_index, x.second));
                if (o_alpha !== x.alpha)
                    report_mismatch($sformatf("alpha %0d, wanted %0d", o_alpha, x.alpha));
                if (o_status !== x.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", o_status, x.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 16);
            i_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= (stall_left == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_request(input t_opcode op, input logic [9:0] idx,
                                input logic [31:0] t, input logic [15:0] fn);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_entry_index <= idx;
        i_frame_time <= t;
        i_frame_number <= fn;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (op == t_op_load) stored_keys[idx] = t;
        else pending_brackets.push_back(bracket_of(fn));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_brackets.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index r, input logic [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (r)
            REG_FRAME_DELTA: delta_reg = d;
            REG_FRAME_COUNT: count_reg = d[10:0];
            default: tol_reg = d[15:0];
        endcase
    endtask

    task automatic set_regs(input logic [31:0] d, input logic [10:0] c, input logic [15:0] t);
        drain();
        write_reg(REG_FRAME_DELTA, d);
        write_reg(REG_FRAME_COUNT, {21'd0, c});
        write_reg(REG_NEAR_TOL, {16'd0, t});
    endtask

    task automatic load_three(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        send_request(t_op_load, 10'd0, a, '0);
        send_request(t_op_load, 10'd1, b, '0);
        send_request(t_op_load, 10'd2, c, '0);
    endtask

    task automatic test_empty_after_reset;
        send_request(t_op_query, '0, '0, 16'd0);
        send_request(t_op_query, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    task automatic test_fill_table;
        for (int i = 0; i < 1024; i++)
            send_request(t_op_load, 10'(i), 32'(i * 2185), '0);
    endtask

    task automatic test_directed;
        set_regs(32'd2185, 11'd1, 16'd0);
        send_request(t_op_query, '0, '0, 16'd5);
        set_regs(32'd2185, 11'd1024, 16'd0);
        send_request(t_op_query, '0, '0, 16'd1023);
        send_request(t_op_query, '0, '0, 16'd1024);
        send_request(t_op_query, '0, '0, 16'hFFFF);
        set_regs(32'hFFFF_FFFF, 11'd2047, 16'hFFFF);
        send_request(t_op_query, '0, '0, 16'hFFFF);
        send_request(t_op_query, '0, '0, 16'd3);
        set_regs(32'd1000, 11'd3, 16'd0);
        load_three(32'd100, 32'd200, 32'd50);
        send_request(t_op_query, '0, '0, 16'd1);
        load_three(32'd100, 32'd200, 32'd300);
        send_request(t_op_query, '0, '0, 16'd7);
        send_request(t_op_query, '0, '0, 16'd0);
        load_three(32'd100, 32'd100, 32'd100);
        send_request(t_op_query, '0, '0, 16'd1);
        set_regs(32'd400, 11'd3, 16'd10);
        load_three(32'd100, 32'd505, 32'd900);
        send_request(t_op_query, '0, '0, 16'd1);
        set_regs(32'd0, 11'd3, 16'd0);
        send_request(t_op_query, '0, '0, 16'd40);
        set_regs(32'd2185, 11'd0, 16'd0);
        send_request(t_op_query, '0, '0, 16'd2);
    endtask

    task automatic test_random;
        int n, nq, sel;
        logic [31:0] d;
        logic [15:0] tl;
        longint t, step;
        while (items_sent < 1950) begin
            sel = $urandom_range(0, 19);
            n = (sel == 0) ? 1024 : (sel == 1) ? $urandom_range(1025, 2047) :
                (sel == 2) ? $urandom_range(0, 1) : $urandom_range(2, 24);
            sel = $urandom_range(0, 5);
            d = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF :
                (sel < 4) ? $urandom_range(1, 200000) : $urandom;
            sel = $urandom_range(0, 5);
            tl = (sel == 0) ? 16'hFFFF : (sel < 3) ? 16'd0 : $urandom_range(0, 2000);
            set_regs(d, 11'(n), tl);
            no_idle = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 3);
            t = (sel == 0) ? 0 : $urandom_range(0, 100000);
            if (n > 1024) n = 1024;
            if (n < 64 || $urandom_range(0, 3) == 0) begin
                for (int i = 0; i < n; i++) begin
                    if (sel == 0) step = d;
                    else if (sel == 3) step = $urandom;
                    else step = $urandom_range(0, 2 * (d % 1000000) + 8);
                    if (sel == 3 && $urandom_range(0, 1)) t = $urandom;
                    send_request(t_op_load, 10'(i),
                                 (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0], '0);
                    t = t + step;
                end
            end
            for (int i = 0; i < 2; i++)
                if ($urandom_range(0, 2) == 0)
                    send_request(t_op_load, 10'($urandom), $urandom, '0);
            nq = $urandom_range(5, 30);
            for (int i = 0; i < nq; i++) begin
                sel = $urandom_range(0, 9);
                send_request(t_op_query, 10'($urandom), $urandom,
                             (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, n + 4)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_after_reset();
        test_fill_table();
        test_directed();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("keyframe_bracket_search_unit_tb OK");
        end else begin
            $display("keyframe_bracket_search_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("keyframe_bracket_search_unit_tb NOT OK");
        $finish;
    end
endmodule
